// ----- hw/rtl/lrts_pkg.sv -----
`default_nettype none

package lrts_pkg;

  localparam int TASK_SLOTS = 16;
  localparam int SLOT_W     = $clog2(TASK_SLOTS);

  localparam int ID_W     = 16;
  localparam int TIME_W   = 32;
  localparam int BURST_W  = 16;
  localparam int SUM_W    = 40;
  localparam int STATUS_W = 2;

  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ZERO = 2'd2;

  localparam logic ACTION_LOAD = 1'b0;
  localparam logic ACTION_TICK = 1'b1;

  typedef struct packed {
    logic               action;
    logic [ID_W-1:0]    task_id;
    logic [TIME_W-1:0]  arrival_time;
    logic [BURST_W-1:0] burst_length;
  } lrts_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                busy_res;
    logic                finished;
    logic [ID_W-1:0]     done_id;
    logic [TIME_W-1:0]   completion_time;
    logic [TIME_W-1:0]   waiting_time;
    logic [TIME_W-1:0]   turnaround_time;
    logic [SUM_W-1:0]    total_waiting;
    logic [SUM_W-1:0]    total_turnaround;
    logic [TIME_W-1:0]   time_now;
  } lrts_out_t;

  // Best candidate seen so far, passed from cell to cell.
  typedef struct packed {
    logic               found;
    logic [BURST_W-1:0] rem;
    logic [ID_W-1:0]    id;
    logic [TIME_W-1:0]  arrival;
    logic [BURST_W-1:0] burst;
    logic [SLOT_W-1:0]  idx;
  } lrts_cand_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic               load_en;
    logic [ID_W-1:0]    load_id;
    logic [TIME_W-1:0]  load_arrival;
    logic [BURST_W-1:0] load_burst;
    logic [TIME_W-1:0]  time_now;
    logic               apply;
    logic               pick_found;
    logic [SLOT_W-1:0]  pick_idx;
  } lrts_cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_SEARCH,
    S_APPLY,
    S_TURN,
    S_WAIT,
    S_SUM,
    S_DONE
  } lrts_state_t;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [TIME_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {{(SUM_W + 1 - TIME_W){1'b0}}, b};
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/lrts_cell.sv -----
`default_nettype none

module lrts_cell (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic [lrts_pkg::SLOT_W-1:0] slot_idx,
  input  wire lrts_pkg::lrts_cmd_t      cmd,
  input  wire logic                     claim_in,
  output logic                          claim_out,
  input  wire lrts_pkg::lrts_cand_t     cand_in,
  output lrts_pkg::lrts_cand_t          cand_out
);

  logic                            used_r;
  logic [lrts_pkg::ID_W-1:0]       id_r;
  logic [lrts_pkg::TIME_W-1:0]     arr_r;
  logic [lrts_pkg::BURST_W-1:0]    burst_r;
  logic [lrts_pkg::BURST_W-1:0]    rem_r;
  lrts_pkg::lrts_cand_t            cand_r;
  lrts_pkg::lrts_cand_t            cand_nxt;
  logic                            take;
  logic                            hit;
  logic                            eligible;

  // A load goes to the first free cell; claim ripples toward higher slots.
  assign take      = cmd.load_en && !used_r && !claim_in;
  assign claim_out = claim_in || !used_r;

  assign hit      = cmd.apply && cmd.pick_found && (cmd.pick_idx == slot_idx);
  assign eligible = used_r && (arr_r <= cmd.time_now);

  // Strict compare keeps the lower slot on a tie.
  always_comb begin
    cand_nxt = cand_in;
    if (eligible && (!cand_in.found || (rem_r > cand_in.rem))) begin
      cand_nxt.found   = 1'b1;
      cand_nxt.rem     = rem_r;
      cand_nxt.id      = id_r;
      cand_nxt.arrival = arr_r;
      cand_nxt.burst   = burst_r;
      cand_nxt.idx     = slot_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
      cand_r <= '0;
    end else begin
      cand_r <= cand_nxt;
      if (take) begin
        used_r <= 1'b1;
      end else if (hit && (rem_r == lrts_pkg::BURST_W'(1))) begin
        used_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      id_r    <= cmd.load_id;
      arr_r   <= cmd.load_arrival;
      burst_r <= cmd.load_burst;
      rem_r   <= cmd.load_burst;
    end else if (hit) begin
      rem_r <= rem_r - lrts_pkg::BURST_W'(1);
    end
  end

  assign cand_out = cand_r;

endmodule

`default_nettype wire

// ----- hw/rtl/longest_remaining_time_scheduler.sv -----
// A load request passes through S_LOAD and S_DONE before its result is registered; a tick
// request walks S_SEARCH, S_APPLY, then S_TURN, S_WAIT and S_SUM when a task finishes.
// The block takes one request at a time, a new one only back in S_IDLE; a tick spends
// longest in the search walking the chain of slot cells; S_DONE holds on a stalled output.
// Reset (rst_n low at a clock edge) empties every slot and clears time and totals.
`default_nettype none

module longest_remaining_time_scheduler (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire lrts_pkg::lrts_in_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output lrts_pkg::lrts_out_t       out_data
);

  // Control state.
  lrts_pkg::lrts_state_t state_r;
  lrts_pkg::lrts_state_t state_nxt;
  logic [lrts_pkg::SLOT_W-1:0] cnt_r;

  // The request being worked on is held here for its whole life in the block.
  lrts_pkg::lrts_in_t req_r;

  // Architectural state outside the cells: time and running totals.
  logic [lrts_pkg::TIME_W-1:0] time_r;
  logic [lrts_pkg::SUM_W-1:0]  sum_wait_r;
  logic [lrts_pkg::SUM_W-1:0]  sum_tat_r;

  // Result fields built up while the request is worked on.
  logic [lrts_pkg::STATUS_W-1:0] status_r;
  logic                          busy_r;
  logic                          fin_r;
  logic [lrts_pkg::ID_W-1:0]     did_r;
  logic [lrts_pkg::TIME_W-1:0]   comp_r;
  logic [lrts_pkg::TIME_W-1:0]   wait_r;
  logic [lrts_pkg::TIME_W-1:0]   tat_r;
  logic [lrts_pkg::TIME_W-1:0]   p_arr_r;
  logic [lrts_pkg::BURST_W-1:0]  p_burst_r;

  // Output register; it lets a new request in while a result still waits.
  logic                out_valid_r;
  lrts_pkg::lrts_out_t out_data_r;

  lrts_pkg::lrts_cmd_t  cmd;
  lrts_pkg::lrts_cand_t cand_link [0:lrts_pkg::TASK_SLOTS];
  logic                 claim_link [0:lrts_pkg::TASK_SLOTS];
  lrts_pkg::lrts_cand_t best;
  logic                 any_free;
  logic                 accept;
  logic                 pick_done;
  logic                 out_free;

  assign accept    = in_valid && !in_stall;
  assign best      = cand_link[lrts_pkg::TASK_SLOTS];
  assign any_free  = claim_link[lrts_pkg::TASK_SLOTS];
  assign pick_done = best.found && (best.rem == lrts_pkg::BURST_W'(1));
  assign out_free  = !out_valid_r || !out_stall;

  // The chain of slot cells. Each cell folds itself into the candidate it gets from
  // the cell below and registers the result, so the best candidate over all slots
  // reaches the top of the chain through the register of every cell, given stable state.
  assign cand_link[0]  = '0;
  assign claim_link[0] = 1'b0;

  for (genvar g = 0; g < lrts_pkg::TASK_SLOTS; g++) begin : g_cell
    lrts_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .slot_idx  (lrts_pkg::SLOT_W'(g)),
      .cmd       (cmd),
      .claim_in  (claim_link[g]),
      .claim_out (claim_link[g+1]),
      .cand_in   (cand_link[g]),
      .cand_out  (cand_link[g+1])
    );
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lrts_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_data.action == lrts_pkg::ACTION_TICK) ?
                      lrts_pkg::S_SEARCH : lrts_pkg::S_LOAD;
        end
      end
      lrts_pkg::S_LOAD: begin
        state_nxt = lrts_pkg::S_DONE;
      end
      lrts_pkg::S_SEARCH: begin
        if (cnt_r == lrts_pkg::SLOT_W'(lrts_pkg::TASK_SLOTS - 1)) begin
          state_nxt = lrts_pkg::S_APPLY;
        end
      end
      lrts_pkg::S_APPLY: begin
        state_nxt = pick_done ? lrts_pkg::S_TURN : lrts_pkg::S_DONE;
      end
      lrts_pkg::S_TURN: begin
        state_nxt = lrts_pkg::S_WAIT;
      end
      lrts_pkg::S_WAIT: begin
        state_nxt = lrts_pkg::S_SUM;
      end
      lrts_pkg::S_SUM: begin
        state_nxt = lrts_pkg::S_DONE;
      end
      lrts_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = lrts_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = lrts_pkg::S_IDLE;
      end
    endcase
  end

  // Output logic: the handshake and the broadcast to the cells.
  always_comb begin
    in_stall         = 1'b1;
    cmd              = '0;
    cmd.load_id      = req_r.task_id;
    cmd.load_arrival = req_r.arrival_time;
    cmd.load_burst   = req_r.burst_length;
    cmd.time_now     = time_r;
    cmd.pick_found   = best.found;
    cmd.pick_idx     = best.idx;
    case (state_r)
      lrts_pkg::S_IDLE: begin
        in_stall = 1'b0;
      end
      lrts_pkg::S_LOAD: begin
        cmd.load_en = (req_r.burst_length != '0);
      end
      lrts_pkg::S_APPLY: begin
        cmd.apply = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lrts_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // The search counter runs only while the chain settles.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (state_r == lrts_pkg::S_SEARCH) begin
      cnt_r <= cnt_r + lrts_pkg::SLOT_W'(1);
    end else begin
      cnt_r <= '0;
    end
  end

  // Time and the saturating totals.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r     <= '0;
      sum_wait_r <= '0;
      sum_tat_r  <= '0;
    end else begin
      if (state_r == lrts_pkg::S_APPLY) begin
        time_r <= time_r + lrts_pkg::TIME_W'(1);
      end
      if (state_r == lrts_pkg::S_WAIT) begin
        sum_tat_r <= lrts_pkg::sat_add(sum_tat_r, tat_r);
      end
      if (state_r == lrts_pkg::S_SUM) begin
        sum_wait_r <= lrts_pkg::sat_add(sum_wait_r, wait_r);
      end
    end
  end

  // Result datapath. The finish steps work on 32 bits: S_TURN subtracts, S_WAIT compares and subtracts.
  always_ff @(posedge clk) begin
    case (state_r)
      lrts_pkg::S_IDLE: begin
        if (accept) begin
          req_r    <= in_data;
          status_r <= lrts_pkg::STATUS_OK;
          busy_r   <= 1'b0;
          fin_r    <= 1'b0;
          did_r    <= '0;
          comp_r   <= '0;
          wait_r   <= '0;
          tat_r    <= '0;
        end
      end
      lrts_pkg::S_LOAD: begin
        if (req_r.burst_length == '0) begin
          status_r <= lrts_pkg::STATUS_ZERO;
        end else if (!any_free) begin
          status_r <= lrts_pkg::STATUS_FULL;
        end else begin
          status_r <= lrts_pkg::STATUS_OK;
        end
      end
      lrts_pkg::S_APPLY: begin
        busy_r    <= best.found;
        fin_r     <= pick_done;
        p_arr_r   <= best.arrival;
        p_burst_r <= best.burst;
        if (pick_done) begin
          did_r  <= best.id;
          comp_r <= time_r + lrts_pkg::TIME_W'(1);
        end
      end
      lrts_pkg::S_TURN: begin
        tat_r <= comp_r - p_arr_r;
      end
      lrts_pkg::S_WAIT: begin
        // A turnaround below the burst only happens after time wraps.
        if (tat_r >= {{(lrts_pkg::TIME_W - lrts_pkg::BURST_W){1'b0}}, p_burst_r}) begin
          wait_r <= tat_r - {{(lrts_pkg::TIME_W - lrts_pkg::BURST_W){1'b0}}, p_burst_r};
        end else begin
          wait_r <= '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == lrts_pkg::S_DONE) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == lrts_pkg::S_DONE) && out_free) begin
      out_data_r.status           <= status_r;
      out_data_r.busy_res         <= busy_r;
      out_data_r.finished         <= fin_r;
      out_data_r.done_id          <= did_r;
      out_data_r.completion_time  <= comp_r;
      out_data_r.waiting_time     <= wait_r;
      out_data_r.turnaround_time  <= tat_r;
      out_data_r.total_waiting    <= sum_wait_r;
      out_data_r.total_turnaround <= sum_tat_r;
      out_data_r.time_now         <= time_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // A completed task always comes from a served tick.
  a_fin_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_data_r.finished || out_data_r.busy_res))
    else $error("finished reported without a served task");

  // Only loads carry a nonzero status, and loads never serve a task.
  a_status_load: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status != lrts_pkg::STATUS_OK)) |-> !out_data_r.busy_res)
    else $error("rejection status on a served tick");

  // Every applied tick moves time forward by exactly one unit.
  a_time_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lrts_pkg::S_APPLY) |=> (time_r == ($past(time_r) + lrts_pkg::TIME_W'(1))))
    else $error("time did not advance by one on a tick");

  // Running totals only grow.
  a_sum_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ((sum_wait_r >= $past(sum_wait_r)) && (sum_tat_r >= $past(sum_tat_r))))
    else $error("running total decreased");
`endif

endmodule

`default_nettype wire
